### rtl/dssg_pkg.sv
package dssg_pkg;

  // Field widths of the input word
  localparam int SPEED_W  = 32;
  localparam int DIR_W    = 8;
  localparam int CODE_W   = 8;
  localparam int IN_DATA_W = 2 * SPEED_W + 2 * DIR_W + CODE_W;

  // Internal count width; speeds saturate to 2^31-1
  localparam int CNT_W = 31;

  // Pin vector layout
  localparam int PIN_W      = 6;
  localparam int PIN_STEP_L = 0;
  localparam int PIN_STEP_R = 1;
  localparam int PIN_DIR_L  = 2;
  localparam int PIN_DIR_R  = 3;
  localparam int PIN_M0     = 4;
  localparam int PIN_M1     = 5;

  localparam int OUT_DATA_W = 8;

  // Microstep codes
  localparam logic [CODE_W-1:0] MS_FULL    = 8'd1;
  localparam logic [CODE_W-1:0] MS_HALF    = 8'd2;
  localparam logic [CODE_W-1:0] MS_QUARTER = 8'd4;
  localparam logic [CODE_W-1:0] MS_EIGHTH  = 8'd8;

  // Direction value that drives a direction pin high
  localparam logic [DIR_W-1:0] DIR_HIGH = 8'd1;

  // Input word kind carried on tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    cnt_t elapsed;
    cnt_t interval;
    cnt_t period;
  } motor_t;

  // Count reaches the interval on this tick
  function automatic logic motor_hit(motor_t m);
    cnt_t e;
    e = m.elapsed + cnt_t'(1);
    return (e >= m.interval);
  endfunction

  // Advance one motor by one tick
  function automatic motor_t motor_adv(motor_t m);
    motor_t r;
    cnt_t   e;
    r = m;
    e = m.elapsed + cnt_t'(1);
    if (e >= m.interval) begin
      r.elapsed  = '0;
      r.interval = m.period;
    end else begin
      r.elapsed = e;
    end
    return r;
  endfunction

  // Saturate a 32-bit speed to 31 bits
  function automatic cnt_t clamp_speed(logic [SPEED_W-1:0] v);
    return v[SPEED_W-1] ? {CNT_W{1'b1}} : v[CNT_W-1:0];
  endfunction

endpackage

### rtl/dual_stepper_step_generator.sv
// Step/direction generator for two stepper drivers. Each input word is
// either one clock tick (in_tuser = 0) or a command frame (in_tuser = 1)
// carrying both half-periods, both directions and a microstep code; a frame
// with a code other than 1, 2, 4 or 8 is dropped and reported with
// out_tuser = 0. One word is taken every clock cycle while the skid stage is
// empty: a single layer of 31-bit increment-and-compare logic per motor
// updates the state and writes the pin levels into the output register, or
// into the one-word skid stage behind it while the output word is held. The
// skid stage keeps in_tready a registered signal; input stalls only when
// both are full. All pins are low after reset and no clearing pass is needed.
module dual_stepper_step_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // speed_left[31:0], speed_right[63:32], direction_left[71:64],
  // direction_right[79:72], microstep_code[87:80]
  input  logic [dssg_pkg::IN_DATA_W-1:0] in_tdata,
  // operation
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // step_left[0], step_right[1], dir_left[2], dir_right[3],
  // mode_m0[4], mode_m1[5], zero[7:6]
  output logic [dssg_pkg::OUT_DATA_W-1:0] out_tdata,
  // frame_accepted
  output logic                          out_tuser
);
  import dssg_pkg::*;

  typedef struct packed {
    logic             accepted;
    logic [PIN_W-1:0] pins;
  } result_t;

  motor_t           left_r, left_nxt;
  motor_t           right_r, right_nxt;
  logic [PIN_W-1:0] pins_r, pins_nxt;

  result_t          out_word_r, skid_word_r, res_nxt;
  logic             out_valid_r, skid_valid_r;

  logic             in_acc;
  logic             code_ok;
  logic [1:0]       mode;
  logic [SPEED_W-1:0] speed_left, speed_right;
  logic [DIR_W-1:0]   direction_left, direction_right;
  logic [CODE_W-1:0]  microstep_code;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  // Unpack the input word
  assign speed_left      = in_tdata[SPEED_W-1:0];
  assign speed_right     = in_tdata[2*SPEED_W-1:SPEED_W];
  assign direction_left  = in_tdata[2*SPEED_W+DIR_W-1:2*SPEED_W];
  assign direction_right = in_tdata[2*SPEED_W+2*DIR_W-1:2*SPEED_W+DIR_W];
  assign microstep_code  = in_tdata[IN_DATA_W-1:2*SPEED_W+2*DIR_W];

  // Decode microstep code into {M1, M0}
  always_comb begin
    code_ok = 1'b1;
    case (microstep_code)
      MS_FULL:    mode = 2'b00;
      MS_HALF:    mode = 2'b01;
      MS_QUARTER: mode = 2'b10;
      MS_EIGHTH:  mode = 2'b11;
      default: begin
        mode    = 2'b00;
        code_ok = 1'b0;
      end
    endcase
  end

  // Apply a tick or a frame to the motor state and pins
  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    pins_nxt  = pins_r;
    res_nxt.accepted = 1'b0;
    if (in_acc) begin
      if (in_tuser == OP_TICK) begin
        if (motor_hit(left_r)) begin
          pins_nxt[PIN_STEP_L] = ~pins_r[PIN_STEP_L];
        end
        if (motor_hit(right_r)) begin
          pins_nxt[PIN_STEP_R] = ~pins_r[PIN_STEP_R];
        end
        left_nxt  = motor_adv(left_r);
        right_nxt = motor_adv(right_r);
      end else if (code_ok) begin
        pins_nxt[PIN_DIR_L] = (direction_left == DIR_HIGH);
        pins_nxt[PIN_DIR_R] = (direction_right == DIR_HIGH);
        pins_nxt[PIN_M0]    = mode[0];
        pins_nxt[PIN_M1]    = mode[1];
        left_nxt.period     = clamp_speed(speed_left);
        right_nxt.period    = clamp_speed(speed_right);
        res_nxt.accepted    = 1'b1;
      end
    end
    res_nxt.pins = pins_nxt;
  end

  // Motor state and pin registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
      pins_r  <= '0;
    end else begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      pins_r  <= pins_nxt;
    end
  end

  // Output register with one-word skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_valid_r  <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!out_valid_r || out_tready) begin
        out_word_r <= res_nxt;
      end else begin
        skid_word_r <= res_nxt;
      end
    end else if (out_tready && skid_valid_r) begin
      out_word_r <= skid_word_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-PIN_W){1'b0}}, out_word_r.pins};
  assign out_tuser  = out_word_r.accepted;

  // Skid stage only fills behind a held output word
  assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  // Elapsed count is zero or stays below its interval
  assert property (@(posedge clk) disable iff (!rst_n)
    (left_r.elapsed == '0) || (left_r.elapsed < left_r.interval))
    else $error("left elapsed count passed its interval");

  assert property (@(posedge clk) disable iff (!rst_n)
    (right_r.elapsed == '0) || (right_r.elapsed < right_r.interval))
    else $error("right elapsed count passed its interval");

  // A tick leaves direction and mode pins alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == OP_TICK) |=> $stable(pins_r[PIN_M1:PIN_DIR_L]))
    else $error("tick changed direction or mode pins");

  // A rejected frame changes nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == OP_FRAME && !code_ok)
      |=> ($stable(pins_r) && $stable(left_r) && $stable(right_r)))
    else $error("rejected frame altered state");

endmodule
